>>> src/assert_macros.svh
// Assertion macros for the port checker file of this block.
// Each macro expects a signal named clk in the calling scope; SDP_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off during reset.
`define SDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define SDP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/sdp_pkg.sv
// Shared constants for the spring direction projection block.
// No dependencies; used by the top level and its port checker.
package sdp_pkg;
	localparam int POS_W  = 32;
	localparam int REST_W = 31;
	localparam int IN_W   = 224;
	localparam int OUT_W  = 96;
	localparam int ROOT_W = 32;
	localparam int QUO_W  = 31;
	localparam int PROD_W = 62;
endpackage

>>> src/spring_direction_projection_unit.sv
// Spring direction projection: full pipeline, one spring per cycle unless stalled.
// Depends on sdp_pkg.
//
// Usage:
//   The slave channel takes one spring per beat. s_axis_tdata holds, from the
//   lowest bit up, first_x, first_y, first_z, second_x, second_y, second_z
//   (32 bits each, signed Q16.16), rest_length (31 bits, unsigned) and one
//   zero pad bit. The master channel returns one beat per spring: tdata holds
//   target_x, target_y, target_z (32 bits each), tuser holds degenerate.
//   Results leave in the order the springs arrived.
// Structure and throughput:
//   From acceptance to the result being shown, a spring passes through five
//   stages of difference, normalization, squaring and summing, 32 stages of
//   a one-bit-per-stage square root and 31 stages of a one-bit-per-stage
//   restoring divider, then the output register. The pipeline accepts a new
//   spring in every cycle in which it is not stalled.
// Stalls and reset:
//   All stages advance together whenever the output register is empty or is
//   being taken. While the receiver holds tready low with a result waiting,
//   the pipeline freezes, s_axis_tready falls and nothing is lost or repeated.
//   The asynchronous reset clears all valid bits; data registers keep any
//   value until overwritten.
module spring_direction_projection_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, rest_length, pad
	input  logic [sdp_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// target_x, target_y, target_z
	output logic [sdp_pkg::OUT_W-1:0]  m_axis_tdata,
	// degenerate
	output logic                       m_axis_tuser
);
	import sdp_pkg::*;

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: differences and magnitudes.
	logic              vld_s1;
	logic [2:0]        neg_s1;
	logic [32:0]       mag_s1 [3];
	logic [REST_W-1:0] rest_s1;

	logic signed [32:0] diff [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = $signed({s_axis_tdata[POS_W*i+31], s_axis_tdata[POS_W*i +: POS_W]})
				- $signed({s_axis_tdata[POS_W*(i+3)+31], s_axis_tdata[POS_W*(i+3) +: POS_W]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= diff[i][32];
				mag_s1[i] <= diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
			end
			rest_s1 <= s_axis_tdata[6*POS_W +: REST_W];
		end
	end

	// Stage 2: largest magnitude and the normalizing shift.
	logic              vld_s2;
	logic [2:0]        neg_s2;
	logic              zero_s2;
	logic              right_s2;
	logic [4:0]        amt_s2;
	logic [32:0]       mag_s2 [3];
	logic [REST_W-1:0] rest_s2;

	logic [32:0] mx;
	logic [5:0]  lead;
	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
		lead = 6'd0;
		for (int b = 0; b < 33; b++) begin
			if (mx[b]) lead = 6'(b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2   <= neg_s1;
			zero_s2  <= (mx == 33'd0);
			right_s2 <= (lead > 6'd30);
			amt_s2   <= (lead > 6'd30) ? 5'(lead - 6'd30) : 5'(6'd30 - lead);
			mag_s2   <= mag_s1;
			rest_s2  <= rest_s1;
		end
	end

	// Stage 3: apply the shift so the largest magnitude lies in [2^30, 2^31).
	logic              vld_s3;
	logic [2:0]        neg_s3;
	logic              zero_s3;
	logic [30:0]       mag_s3 [3];
	logic [REST_W-1:0] rest_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] wide;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				wide = right_s2 ? ({31'd0, mag_s2[i]} >> amt_s2)
					: ({31'd0, mag_s2[i]} << amt_s2);
				mag_s3[i] <= wide[30:0];
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			rest_s3 <= rest_s2;
		end
	end

	// Stage 4: squares for the norm and products for the scaled direction.
	logic              vld_s4;
	logic [2:0]        neg_s4;
	logic              zero_s4;
	logic [PROD_W-1:0] sq_s4   [3];
	logic [PROD_W-1:0] prod_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i]   <= mag_s3[i] * mag_s3[i];
				prod_s4[i] <= rest_s3 * mag_s3[i];
			end
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Square root pipeline; entry 0 is the sum stage, entry k+1 follows bit k.
	logic              sq_vld  [0:32];
	logic [2:0]        sq_neg  [0:32];
	logic              sq_zero [0:32];
	logic [63:0]       sq_rad  [0:32];
	logic [33:0]       sq_rem  [0:32];
	logic [ROOT_W-1:0] sq_root [0:32];
	logic [PROD_W-1:0] sq_prod [0:32][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld[0] <= 1'b0;
		end else if (en) begin
			sq_vld[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0]  <= {2'b00, sq_s4[0]} + {2'b00, sq_s4[1]} + {2'b00, sq_s4[2]};
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_neg[0]  <= neg_s4;
			sq_zero[0] <= zero_s4;
			sq_prod[0] <= prod_s4;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		logic [35:0] shifted;
		logic [35:0] trial;
		logic        take;
		assign shifted = {sq_rem[k], sq_rad[k][63:62]};
		assign trial   = {2'b00, sq_root[k], 2'b01};
		assign take    = (shifted >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[k+1]  <= {sq_rad[k][61:0], 2'b00};
				sq_rem[k+1]  <= take ? 34'(shifted - trial) : shifted[33:0];
				sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], take};
				sq_neg[k+1]  <= sq_neg[k];
				sq_zero[k+1] <= sq_zero[k];
				sq_prod[k+1] <= sq_prod[k];
			end
		end
	end

	// Divider pipeline: the quotient is below 2^31, so the upper product bits
	// seed the remainder and 31 steps bring in the rest.
	logic              dv_vld  [1:31];
	logic [2:0]        dv_neg  [1:31];
	logic              dv_zero [1:31];
	logic [ROOT_W-1:0] dv_den  [1:31];
	logic [31:0]       dv_rem  [1:31][3];
	logic [30:0]       dv_low  [1:31][3];
	logic [QUO_W-1:0]  dv_quo  [1:31][3];

	for (genvar j = 0; j < 31; j++) begin : g_div
		logic              vin;
		logic [2:0]        nin;
		logic              zin;
		logic [ROOT_W-1:0] din;
		logic [31:0]       rin [3];
		logic [30:0]       lin [3];
		logic [QUO_W-1:0]  qin [3];
		logic [32:0]       sh  [3];
		logic              ge  [3];

		if (j == 0) begin : g_first
			assign vin = sq_vld[32];
			assign nin = sq_neg[32];
			assign zin = sq_zero[32];
			assign din = sq_root[32];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rin[l] = {1'b0, sq_prod[32][l][61:31]};
				assign lin[l] = sq_prod[32][l][30:0];
				assign qin[l] = '0;
			end
		end else begin : g_next
			assign vin = dv_vld[j];
			assign nin = dv_neg[j];
			assign zin = dv_zero[j];
			assign din = dv_den[j];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rin[l] = dv_rem[j][l];
				assign lin[l] = dv_low[j][l];
				assign qin[l] = dv_quo[j][l];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_cmp
			assign sh[l] = {rin[l], lin[l][30]};
			assign ge[l] = (sh[l] >= {1'b0, din});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld[j+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_neg[j+1]  <= nin;
				dv_zero[j+1] <= zin;
				dv_den[j+1]  <= din;
				for (int l = 0; l < 3; l++) begin
					dv_rem[j+1][l] <= ge[l] ? 32'(sh[l] - {1'b0, din}) : sh[l][31:0];
					dv_low[j+1][l] <= {lin[l][29:0], 1'b0};
					dv_quo[j+1][l] <= {qin[l][QUO_W-2:0], ge[l]};
				end
			end
		end
	end

	// Output register: restore signs, zero the vector for coinciding endpoints.
	logic            vld_q;
	logic [OUT_W-1:0] data_q;
	logic            user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld[31];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] mag;
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				mag = {1'b0, dv_quo[31][l]};
				if (dv_zero[31]) begin
					data_q[32*l +: 32] <= '0;
				end else begin
					data_q[32*l +: 32] <= dv_neg[31][l] ? 32'(-mag) : mag;
				end
			end
			user_q <= dv_zero[31];
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
endmodule

>>> src/sdp_port_checker.sv
// Port-level checks for the spring direction projection block, bound to it.
// Depends on sdp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdp_port_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [sdp_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [sdp_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                      m_axis_tuser
);
	import sdp_pkg::*;

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata[IN_W-1] == 1'b0);

	`SDP_ASSERT(a_degen_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "degenerate result carries a nonzero vector")
	`SDP_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled while the output register is empty")
	`SDP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`SDP_ASSERT(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready |-> !in_beat, "input beat taken while the pipeline is frozen")
endmodule

bind spring_direction_projection_unit sdp_port_checker u_sdp_port_checker (.*);

>>> bench/spring_direction_projection_unit_tb.sv
// Self-checking bench for the spring direction projection unit.
// Depends on sdp_pkg and spring_direction_projection_unit; predicts each target in place.
module spring_direction_projection_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdp_pkg::*;

	typedef struct packed {
		logic        degenerate;
		logic [31:0] target_z;
		logic [31:0] target_y;
		logic [31:0] target_x;
	} target_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                m_axis_tuser;

	// Expected targets in arrival order, and the pacing knobs for both sides.
	target_t target_q[$];
	int      fail_count;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      hold_cycles;
	longint  cycle_count;

	spring_direction_projection_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Floor square root of a 64-bit value, digit by digit.
	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] bit_val;
		root = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > v)
			bit_val >>= 2;
		while (bit_val != 0) begin
			if (v >= root + bit_val) begin
				v -= root + bit_val;
				root = (root >> 1) + bit_val;
			end else begin
				root >>= 1;
			end
			bit_val >>= 2;
		end
		return root;
	endfunction

	// Scales the unit vector from the second endpoint to the first by the rest length.
	// The difference is block-normalized so its largest magnitude lies in [2^30, 2^31).
	function automatic target_t project_spring(logic signed [31:0] p1[3],
			logic signed [31:0] p2[3], logic [30:0] rest);
		target_t            t;
		logic signed [32:0] diff;
		logic [63:0]        mag[3];
		logic               neg[3];
		logic [63:0]        peak;
		logic [63:0]        sum;
		logic [63:0]        norm;
		logic [63:0]        quo;
		logic [31:0]        comp[3];
		peak = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			diff = 33'(p1[i]) - 33'(p2[i]);
			neg[i] = diff < 0;
			mag[i] = neg[i] ? 64'(-diff) : 64'(diff);
			if (mag[i] > peak)
				peak = mag[i];
		end
		if (peak == 0) begin
			t = '0;
			t.degenerate = 1'b1;
			return t;
		end
		while (peak >= (64'd1 << 31)) begin
			peak >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (peak < (64'd1 << 30)) begin
			peak <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += mag[i] * mag[i];
		norm = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			quo = (64'(rest) * mag[i]) / norm;
			comp[i] = neg[i] ? 32'(-quo) : 32'(quo);
		end
		t.target_x = comp[0];
		t.target_y = comp[1];
		t.target_z = comp[2];
		t.degenerate = 1'b0;
		return t;
	endfunction

	// Offers one spring until it is taken, with random idle cycles first.
	// tvalid stays high after the beat so the next spring can follow directly.
	task automatic send_spring(logic signed [31:0] p1[3], logic signed [31:0] p2[3],
			logic [30:0] rest);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {1'b0, rest, p2[2], p2[1], p2[0], p1[2], p1[1], p1[0]};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		target_q = {target_q, project_spring(p1, p2, rest)};
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(4000)) - 2000);
			2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(15);
			default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
				: 32'h8000_0000 + $urandom_range(3);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] a[3];
		logic signed [31:0] b[3];
		// Coinciding endpoints, including the field extremes.
		a = '{0, 0, 0}; b = a;
		send_spring(a, b, 31'h7FFF_FFFF);
		a = '{32'h7FFF_FFFF, 32'h8000_0000, 5}; b = a;
		send_spring(a, b, 31'd65536);
		// Zero rest length with distinct endpoints.
		a = '{65536, 0, 0}; b = '{0, 0, 0};
		send_spring(a, b, 0);
		// Largest possible differences in every direction and sign.
		a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
		b = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		send_spring(a, b, 31'h7FFF_FFFF);
		send_spring(b, a, 31'h7FFF_FFFF);
		// Smallest nonzero differences on each axis.
		for (int i = 0; i < 3; i++) begin
			a = '{0, 0, 0}; b = a; a[i] = 1;
			send_spring(a, b, 31'd65536);
			send_spring(b, a, 31'h7FFF_FFFF);
		end
		a = '{1, -1, 1}; b = '{0, 0, 0};
		send_spring(a, b, 31'd1);
		a = '{3 << 16, 4 << 16, 0}; b = '{0, 0, 0};
		send_spring(a, b, 31'd5 << 16);
		a = '{32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000}; b = '{0, 0, 32'h8000_0000};
		send_spring(a, b, 31'h4000_0000);
	endtask

	task automatic test_random(int count);
		logic signed [31:0] a[3];
		logic signed [31:0] b[3];
		logic [30:0]        rest;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 3; i++) begin
				a[i] = rand_coord();
				b[i] = ($urandom_range(19) == 0) ? a[i] : rand_coord();
			end
			case ($urandom_range(3))
				0: rest = 31'($urandom);
				1: rest = 31'($urandom_range(1 << 20));
				2: rest = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
				default: rest = 31'($urandom) >> $urandom_range(30);
			endcase
			send_spring(a, b, rest);
		end
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall its input.
	// The sender goes quiet once its last spring is taken.
	task automatic test_backpressure();
		hold_cycles = 200;
		test_random(120);
		s_axis_tvalid <= 1'b0;
		wait (hold_cycles == 0);
	endtask

	task automatic drain();
		while (target_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Ready driver: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare every accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		target_t got;
		target_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (target_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				fail_count++;
			end else begin
				want = target_q.pop_front();
				if (got.target_x !== want.target_x) begin
					$display("%0t: target_x expected %h actual %h", $time,
						want.target_x, got.target_x);
					fail_count++;
				end
				if (got.target_y !== want.target_y) begin
					$display("%0t: target_y expected %h actual %h", $time,
						want.target_y, got.target_y);
					fail_count++;
				end
				if (got.target_z !== want.target_z) begin
					$display("%0t: target_z expected %h actual %h", $time,
						want.target_z, got.target_z);
					fail_count++;
				end
				if (got.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time,
						want.degenerate, got.degenerate);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("spring_direction_projection_unit: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		fail_count    = 0;
		hold_cycles   = 0;
		cycle_count   = 0;
		send_idle_pct = 9;
		recv_idle_pct = 77;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(110);
		send_idle_pct = 77;
		recv_idle_pct = 9;
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(90);
		test_backpressure();
		drain();
		if (fail_count == 0)
			$display("spring_direction_projection_unit: match");
		else
			$display("spring_direction_projection_unit: mismatch");
		$finish;
	end
endmodule
